/* sv/toeq_pkg.sv */
package toeq_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_PEEK   = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  localparam int unsigned HeadTimeW = 16;
  localparam int unsigned CountW    = 5;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

/* sv/toeq_cell.sv */
module toeq_cell import toeq_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 occupied_i,
  input  logic                 left_ge_i,
  input  logic [TIME_BITS-1:0] left_time_i,
  input  logic                 left_kind_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  input  logic                 right_kind_i,
  input  logic [TIME_BITS-1:0] new_time_i,
  input  logic                 new_kind_i,
  output logic                 ge_o,
  output logic [TIME_BITS-1:0] time_o,
  output logic                 kind_o
);

  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 kind_q, kind_d;

  // at or past the insertion point
  assign ge_o = !occupied_i || (time_q >= new_time_i);

  always_comb begin
    time_d = time_q;
    kind_d = kind_q;
    if (ctrl_i.ins && ge_o) begin
      if (left_ge_i) begin
        time_d = left_time_i;
        kind_d = left_kind_i;
      end else begin
        time_d = new_time_i;
        kind_d = new_kind_i;
      end
    end else if (ctrl_i.pop) begin
      time_d = right_time_i;
      kind_d = right_kind_i;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    kind_q <= kind_d;
  end

  assign time_o = time_q;
  assign kind_o = kind_q;

endmodule

/* sv/time_ordered_event_queue.sv */
// Sorted event queue built as a row of CAPACITY cells, each holding one event
// (time and kind) in ascending time order, earliest in the first cell. Every
// cell compares the new time at once and either holds, shifts right, takes the
// new event or, on a pop, shifts left, and a word is accepted every cycle while
// the result register is free or being drained. An insert goes ahead of stored
// events of equal time; an insert into a full queue is dropped with status 2;
// peek or pop on an empty queue gives status 1. Each input word yields exactly
// one result word carrying the head event (for a pop, the popped one), status
// and the stored count after the operation.
module time_ordered_event_queue import toeq_pkg::*; #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] event_time_i,
  input  logic        event_kind_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        head_valid_o,
  output logic [15:0] head_time_o,
  output logic        head_kind_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]      count_q, count_d;
  logic                 out_valid_q;
  logic                 head_valid_q;
  logic [15:0]          head_time_q;
  logic                 head_kind_q;
  status_e              status_q, status_d;

  logic                 fire;
  logic [TIME_BITS-1:0] new_time;
  logic                 full, empty;
  cell_ctrl_t           ctrl;
  logic                 head_valid_d;
  logic [TIME_BITS-1:0] head_time_d;
  logic                 head_kind_d;

  logic [CAPACITY-1:0]  ge;
  logic [TIME_BITS-1:0] cell_time [CAPACITY];
  logic [CAPACITY-1:0]  cell_kind;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign new_time   = TIME_BITS'(event_time_i);
  assign full       = (count_q == CntW'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl         = '0;
    count_d      = count_q;
    status_d     = ST_OK;
    head_valid_d = !empty;
    head_time_d  = cell_time[0];
    head_kind_d  = cell_kind[0];
    unique case (op_e'(op_i))
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins     = fire;
          count_d      = count_q + CntW'(1);
          head_valid_d = 1'b1;
          if (ge[0]) begin
            head_time_d = new_time;
            head_kind_d = event_kind_i;
          end
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.pop = fire;
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end
      end
    endcase
    if (!head_valid_d) begin
      head_time_d = '0;
      head_kind_d = 1'b0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 left_ge;
    logic [TIME_BITS-1:0] left_time, right_time;
    logic                 left_kind, right_kind;
    logic                 occupied;

    assign occupied = count_q > CntW'(i);

    if (i == 0) begin : g_first
      assign left_ge   = 1'b0;
      assign left_time = new_time;
      assign left_kind = event_kind_i;
    end else begin : g_mid
      assign left_ge   = ge[i-1];
      assign left_time = cell_time[i-1];
      assign left_kind = cell_kind[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_time = cell_time[i];
      assign right_kind = cell_kind[i];
    end else begin : g_inner
      assign right_time = cell_time[i+1];
      assign right_kind = cell_kind[i+1];
    end

    toeq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occupied),
      .left_ge_i   (left_ge),
      .left_time_i (left_time),
      .left_kind_i (left_kind),
      .right_time_i(right_time),
      .right_kind_i(right_kind),
      .new_time_i  (new_time),
      .new_kind_i  (event_kind_i),
      .ge_o        (ge[i]),
      .time_o      (cell_time[i]),
      .kind_o      (cell_kind[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (fire) begin
      head_valid_q <= head_valid_d;
      head_time_q  <= HeadTimeW'(head_time_d);
      head_kind_q  <= head_kind_d;
      status_q     <= status_d;
    end
  end

  logic [CountW-1:0] count_out_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      count_out_q <= CountW'(count_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign head_valid_o  = head_valid_q;
  assign head_time_o   = head_time_q;
  assign head_kind_o   = head_kind_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;

endmodule

/* sim/time_ordered_event_queue_tb.sv */
module time_ordered_event_queue_tb import toeq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap        = 16;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PhaseWords = 567;
  localparam int unsigned DrainWait  = 20;
  localparam logic [1:0]  OpUnused   = 2'd3;

  typedef struct packed {
    logic        head_valid;
    logic [15:0] head_time;
    logic        head_kind;
    status_e     status;
    logic [4:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] event_time;
    logic        event_kind;
    logic        typed;
    result_t     res;
  } step_t;

  localparam result_t NoRes = '{1'b0, 16'd0, 1'b0, ST_OK, 5'd0};

  localparam step_t DirectedSteps [25] = '{
    '{OP_PEEK,   16'h0000, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, ST_EMPTY, 5'd0}},
    '{OP_POP,    16'h0000, 1'b0, 1'b1, '{1'b0, 16'h0000, 1'b0, ST_EMPTY, 5'd0}},
    '{OpUnused,  16'hFFFF, 1'b1, 1'b1, '{1'b0, 16'h0000, 1'b0, ST_EMPTY, 5'd0}},
    '{OP_INSERT, 16'hFFFF, 1'b1, 1'b1, '{1'b1, 16'hFFFF, 1'b1, ST_OK, 5'd1}},
    '{OP_INSERT, 16'h0000, 1'b0, 1'b1, '{1'b1, 16'h0000, 1'b0, ST_OK, 5'd2}},
    '{OP_INSERT, 16'h0000, 1'b1, 1'b1, '{1'b1, 16'h0000, 1'b1, ST_OK, 5'd3}},
    '{OP_PEEK,   16'h1234, 1'b0, 1'b0, NoRes},
    '{OpUnused,  16'h0000, 1'b0, 1'b0, NoRes},
    '{OP_POP,    16'h0000, 1'b0, 1'b1, '{1'b1, 16'h0000, 1'b1, ST_OK, 5'd2}},
    '{OP_INSERT, 16'h0001, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'hFFFF, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h8000, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'h7FFF, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h5555, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'hAAAA, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h0001, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h00FF, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'hFF00, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h1234, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'h8000, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h0F0F, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'hF0F0, 1'b0, 1'b0, NoRes},
    '{OP_INSERT, 16'h0002, 1'b1, 1'b0, NoRes},
    '{OP_INSERT, 16'hBEEF, 1'b1, 1'b1, '{1'b1, 16'h0000, 1'b0, ST_FULL, 5'd16}},
    '{OP_POP,    16'h0000, 1'b0, 1'b1, '{1'b1, 16'h0000, 1'b0, ST_OK, 5'd15}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  op_i;
  logic [15:0] event_time_i;
  logic        event_kind_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        head_valid_o;
  logic [15:0] head_time_o;
  logic        head_kind_o;
  logic [1:0]  status_o;
  logic [4:0]  entry_count_o;

  logic [15:0] pred_times [Cap];
  logic        pred_kinds [Cap];
  int unsigned pred_count;

  result_t     expected_results [$];
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned stall_cycles;

  time_ordered_event_queue #(
    .CAPACITY  (Cap),
    .TIME_BITS (16)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .event_time_i  (event_time_i),
    .event_kind_i  (event_kind_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .head_valid_o  (head_valid_o),
    .head_time_o   (head_time_o),
    .head_kind_o   (head_kind_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic result_t head_of_queue();
    result_t r;
    r = NoRes;
    if (pred_count > 0) begin
      r.head_valid = 1'b1;
      r.head_time  = pred_times[0];
      r.head_kind  = pred_kinds[0];
    end
    return r;
  endfunction

  function automatic result_t predict_head(input logic [1:0] op, input logic [15:0] t,
                                           input logic k);
    result_t     r;
    int unsigned pos;
    if (op == OP_INSERT) begin
      if (pred_count >= Cap) begin
        r = head_of_queue();
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < pred_count && pred_times[pos] < t) pos++;
        for (int unsigned i = pred_count; i > pos; i--) begin
          pred_times[i] = pred_times[i-1];
          pred_kinds[i] = pred_kinds[i-1];
        end
        pred_times[pos] = t;
        pred_kinds[pos] = k;
        pred_count++;
        r = head_of_queue();
      end
    end else if (op == OP_POP) begin
      r = head_of_queue();
      if (pred_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int unsigned i = 1; i < pred_count; i++) begin
          pred_times[i-1] = pred_times[i];
          pred_kinds[i-1] = pred_kinds[i];
        end
        pred_count--;
      end
    end else begin
      r = head_of_queue();
      if (pred_count == 0) r.status = ST_EMPTY;
    end
    r.entry_count = pred_count[4:0];
    return r;
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [15:0] t, input logic k,
                           input logic typed, input result_t typed_res);
    result_t r;
    @(negedge clk_i);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    event_time_i <= t;
    event_kind_i <= k;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_head(op, t, k);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_words);
    int unsigned left;
    int unsigned mode;
    int unsigned pick;
    int unsigned ins_pct;
    int unsigned peek_pct;
    logic [1:0]  op;
    logic [15:0] t;
    left = 0;
    mode = 0;
    for (int unsigned w = 0; w < n_words; w++) begin
      // alternate fill-heavy, drain-heavy and mixed stretches to hit full and empty
      if (left == 0) begin
        left = $urandom_range(10, 60);
        mode = $urandom_range(2);
      end
      left--;
      ins_pct  = (mode == 0) ? 70 : (mode == 1) ? 25 : 45;
      peek_pct = ins_pct + 10;
      pick = $urandom_range(99);
      if (pick < ins_pct)        op = OP_INSERT;
      else if (pick < peek_pct)  op = OP_PEEK;
      else if (pick < peek_pct + 3) op = OpUnused;
      else                       op = OP_POP;
      pick = $urandom_range(9);
      if (pick < 4)       t = 16'($urandom_range(7));
      else if (pick == 4) t = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else                t = 16'($urandom_range(65535));
      send_word(op, t, 1'($urandom_range(1)), 1'b0, NoRes);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result word: head_time %h status %0d count %0d",
                 $time, head_time_o, status_o, entry_count_o);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (head_valid_o !== exp_r.head_valid) begin
          $display("%0t head_valid expected %0b got %0b", $time, exp_r.head_valid,
                   head_valid_o);
          mismatch_count++;
        end
        if (head_time_o !== exp_r.head_time) begin
          $display("%0t head_time expected %h got %h", $time, exp_r.head_time, head_time_o);
          mismatch_count++;
        end
        if (head_kind_o !== exp_r.head_kind) begin
          $display("%0t head_kind expected %0b got %0b", $time, exp_r.head_kind, head_kind_o);
          mismatch_count++;
        end
        if (status_o !== exp_r.status) begin
          $display("%0t status expected %0d got %0d", $time, exp_r.status, status_o);
          mismatch_count++;
        end
        if (entry_count_o !== exp_r.entry_count) begin
          $display("%0t entry_count expected %0d got %0d", $time, exp_r.entry_count,
                   entry_count_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    op_i              = OP_PEEK;
    event_time_i      = 16'd0;
    event_kind_i      = 1'b0;
    out_ready_i       = 1'b0;
    pred_count        = 0;
    mismatch_count    = 0;
    stall_cycles      = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedSteps[i]) begin
      send_word(DirectedSteps[i].op, DirectedSteps[i].event_time, DirectedSteps[i].event_kind,
                DirectedSteps[i].typed, DirectedSteps[i].res);
    end
    wait_drained();

    sender_idle_pct   = 18;
    receiver_idle_pct = 67;
    run_random(PhaseWords);
    wait_drained();

    sender_idle_pct   = 67;
    receiver_idle_pct = 18;
    run_random(PhaseWords);
    wait_drained();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(PhaseWords);
    wait_drained();

    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
